// File: hw/rtl/gww_pkg.sv
// Shared constants, codes and types of the greedy word wrap block.
package gww_pkg;

  localparam int LINE_BYTES  = 32;
  localparam int STORE_LINES = 8;
  localparam int STORE_DEPTH = LINE_BYTES - 1;
  localparam int MAX_RESULTS = 40;
  localparam int MAX_WRITES  = MAX_RESULTS - 1;

  localparam logic [7:0] NUL_CODE   = 8'd0;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHKWRAP,
    ST_DPLACE,
    ST_RSTART,
    ST_RREAD,
    ST_RPLACE,
    ST_ZTERM,
    ST_ZFIN,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_STORE,
    OP_DIRECT,
    OP_SPACE,
    OP_RS_WRAP,
    OP_RS_SPACE,
    OP_READ,
    OP_NEWLINE,
    OP_PUTCHAR,
    OP_ZTERM,
    OP_ZFIN,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic src_mem;
  } cmd_t;

  typedef struct packed {
    logic is_zero;
    logic is_space;
    logic full;
    logic stream;
    logic col_zero;
    logic wlen_zero;
    logic wrap_chk;
    logic col_at_w;
    logic loop_last;
    logic wr_ok;
    logic push_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [4:0] ew;
    logic [3:0] elim;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] line_index;
    logic [4:0] column;
    logic [7:0] ch;
    logic [3:0] total;
  } res_t;

endpackage

// File: hw/rtl/gww_cfg.sv
// Configuration registers of the word wrap block with their effective ranges.
module gww_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gww_pkg::cfg_t      cfg
);

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_LIMIT = 1'b1;
  localparam logic [4:0] WIDTH_RST = 5'd26;
  localparam logic [3:0] LIMIT_RST = 4'd8;

  logic [4:0] width_r, width_nxt;
  logic [3:0] limit_r, limit_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    width_nxt = width_r;
    limit_nxt = limit_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_WIDTH: width_nxt = pwdata[4:0];
        REG_LIMIT: limit_nxt = pwdata[3:0];
        default:   width_nxt = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST;
      limit_r <= LIMIT_RST;
    end else begin
      width_r <= width_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH: prdata = {27'd0, width_r};
      REG_LIMIT: prdata = {28'd0, limit_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.ew = (width_r == 5'd0) ? 5'd1 : width_r;
    if (limit_r == 4'd0) begin
      cfg.elim = 4'd1;
    end else if (limit_r > 4'(gww_pkg::STORE_LINES)) begin
      cfg.elim = 4'(gww_pkg::STORE_LINES);
    end else begin
      cfg.elim = limit_r;
    end
  end

endmodule

// File: hw/rtl/gww_ctrl.sv
// Sequencing state machine of the word wrap block.
module gww_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gww_pkg::sts_t    sts,
  output gww_pkg::cmd_t    cmd
);

  gww_pkg::state_t state_r, state_nxt;
  logic direct;
  logic place_done;

  assign direct     = sts.stream || (sts.col_zero && sts.wlen_zero);
  assign place_done = sts.wr_ok && !sts.col_at_w;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gww_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gww_pkg::ST_DISPATCH;
      end
      gww_pkg::ST_DISPATCH: begin
        if (sts.is_zero) begin
          state_nxt = (!sts.full && !sts.wlen_zero) ? gww_pkg::ST_RSTART : gww_pkg::ST_ZTERM;
        end else if (sts.is_space) begin
          state_nxt = (!sts.full && !sts.wlen_zero) ? gww_pkg::ST_RSTART : gww_pkg::ST_FINISH;
        end else if (sts.full) begin
          state_nxt = gww_pkg::ST_FINISH;
        end else if (direct) begin
          state_nxt = gww_pkg::ST_DPLACE;
        end else begin
          state_nxt = gww_pkg::ST_CHKWRAP;
        end
      end
      gww_pkg::ST_CHKWRAP: begin
        state_nxt = sts.wrap_chk ? gww_pkg::ST_RSTART : gww_pkg::ST_FINISH;
      end
      gww_pkg::ST_DPLACE: begin
        if (sts.full || place_done) state_nxt = gww_pkg::ST_FINISH;
      end
      gww_pkg::ST_RSTART: begin
        if (sts.wr_ok) state_nxt = gww_pkg::ST_RREAD;
      end
      gww_pkg::ST_RREAD: begin
        if (sts.full) begin
          state_nxt = sts.is_zero ? gww_pkg::ST_ZTERM : gww_pkg::ST_FINISH;
        end else begin
          state_nxt = gww_pkg::ST_RPLACE;
        end
      end
      gww_pkg::ST_RPLACE: begin
        if (sts.full || (place_done && sts.loop_last)) begin
          state_nxt = sts.is_zero ? gww_pkg::ST_ZTERM : gww_pkg::ST_FINISH;
        end else if (place_done) begin
          state_nxt = gww_pkg::ST_RREAD;
        end
      end
      gww_pkg::ST_ZTERM: begin
        if (sts.full || sts.wr_ok) state_nxt = gww_pkg::ST_ZFIN;
      end
      gww_pkg::ST_ZFIN: begin
        if (sts.push_ok) state_nxt = gww_pkg::ST_FINISH;
      end
      gww_pkg::ST_FINISH: begin
        if (!sts.pend_valid || sts.out_free) state_nxt = gww_pkg::ST_IDLE;
      end
      default: state_nxt = gww_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = gww_pkg::OP_NONE;
    cmd.src_mem = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r) inside
      gww_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = gww_pkg::OP_ACCEPT;
      end
      gww_pkg::ST_DISPATCH: begin
        if (sts.is_zero) begin
          cmd.op = gww_pkg::OP_NONE;
        end else if (sts.is_space) begin
          cmd.op = gww_pkg::OP_SPACE;
        end else if (sts.full) begin
          cmd.op = gww_pkg::OP_NONE;
        end else if (direct) begin
          cmd.op = gww_pkg::OP_DIRECT;
        end else begin
          cmd.op = gww_pkg::OP_STORE;
        end
      end
      gww_pkg::ST_CHKWRAP: cmd.op = gww_pkg::OP_NONE;
      gww_pkg::ST_DPLACE, gww_pkg::ST_RPLACE: begin
        cmd.src_mem = (state_r == gww_pkg::ST_RPLACE);
        if (!sts.full && sts.wr_ok) begin
          cmd.op = sts.col_at_w ? gww_pkg::OP_NEWLINE : gww_pkg::OP_PUTCHAR;
        end
      end
      gww_pkg::ST_RSTART: begin
        if (sts.wr_ok) cmd.op = sts.wrap_chk ? gww_pkg::OP_RS_WRAP : gww_pkg::OP_RS_SPACE;
      end
      gww_pkg::ST_RREAD: begin
        if (!sts.full) cmd.op = gww_pkg::OP_READ;
      end
      gww_pkg::ST_ZTERM: begin
        if (!sts.full && sts.wr_ok) cmd.op = gww_pkg::OP_ZTERM;
      end
      gww_pkg::ST_ZFIN: begin
        if (sts.push_ok) cmd.op = gww_pkg::OP_ZFIN;
      end
      gww_pkg::ST_FINISH: begin
        if (sts.pend_valid && sts.out_free) cmd.op = gww_pkg::OP_FLUSH;
      end
      default: cmd.op = gww_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gww_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/gww_dp.sv
// Datapath of the word wrap block: word buffer, line position and result registers.
module gww_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  gww_pkg::cmd_t    cmd,
  input  gww_pkg::cfg_t    cfg,
  input  logic [7:0]       in_char_code,
  input  logic             out_stall,
  output gww_pkg::sts_t    sts,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_line_index,
  output logic [4:0]       out_column,
  output logic [7:0]       out_char_code_out,
  output logic [3:0]       out_line_total,
  output logic             out_last
);

  logic [7:0] store_mem [gww_pkg::STORE_DEPTH];

  logic [7:0]       char_r, char_nxt;
  logic [4:0]       wlen_r, wlen_nxt;
  logic [4:0]       col_r, col_nxt;
  logic [3:0]       line_r, line_nxt;
  logic             full_r, full_nxt;
  logic             stream_r, stream_nxt;
  logic [4:0]       len_r, len_nxt;
  logic [4:0]       idx_r, idx_nxt;
  logic [7:0]       rdata_r;
  logic [5:0]       nwr_r, nwr_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  gww_pkg::res_t    pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  gww_pkg::res_t    out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  logic             is_wr_op;
  logic             suppress;
  logic             wr_emit;
  logic             push;
  logic             mv_out;
  logic             out_free;
  logic             ended;
  logic [3:0]       line_inc;
  logic [3:0]       total;
  gww_pkg::res_t    new_res;

  assign out_free = !out_valid_r || !out_stall;
  assign suppress = (nwr_r >= 6'(gww_pkg::MAX_WRITES));
  assign ended    = (char_r == gww_pkg::NUL_CODE) || (char_r == gww_pkg::SPACE_CODE);
  assign line_inc = line_r + 4'd1;
  assign total    = full_r ? cfg.elim
                  : line_r + {3'd0, ((col_r != 5'd0) || (line_r == 4'd0))};

  always_comb begin
    is_wr_op           = 1'b1;
    new_res.kind       = gww_pkg::KIND_TERM;
    new_res.line_index = line_r[2:0];
    new_res.column     = col_r;
    new_res.ch         = gww_pkg::NUL_CODE;
    new_res.total      = 4'd0;
    unique case (cmd.op) inside
      gww_pkg::OP_NEWLINE, gww_pkg::OP_RS_WRAP, gww_pkg::OP_ZTERM: begin
        new_res.kind = gww_pkg::KIND_TERM;
      end
      gww_pkg::OP_PUTCHAR: begin
        new_res.kind = gww_pkg::KIND_CHAR;
        new_res.ch   = cmd.src_mem ? rdata_r : char_r;
      end
      gww_pkg::OP_RS_SPACE: begin
        new_res.kind = gww_pkg::KIND_CHAR;
        new_res.ch   = gww_pkg::SPACE_CODE;
      end
      gww_pkg::OP_ZFIN: begin
        is_wr_op           = 1'b0;
        new_res.kind       = gww_pkg::KIND_DONE;
        new_res.line_index = 3'd0;
        new_res.column     = 5'd0;
        new_res.total      = total;
      end
      default: is_wr_op = 1'b0;
    endcase
  end

  assign wr_emit = is_wr_op && !suppress;
  assign push    = wr_emit || (cmd.op == gww_pkg::OP_ZFIN);
  assign mv_out  = (push && pend_valid_r) || (cmd.op == gww_pkg::OP_FLUSH);

  always_comb begin
    char_nxt       = char_r;
    wlen_nxt       = wlen_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    full_nxt       = full_r;
    stream_nxt     = stream_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    nwr_nxt        = wr_emit ? nwr_r + 6'd1 : nwr_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;

    unique case (cmd.op)
      gww_pkg::OP_ACCEPT: begin
        char_nxt = in_char_code;
        nwr_nxt  = 6'd0;
        if (!full_r && (line_r >= cfg.elim)) full_nxt = 1'b1;
      end
      gww_pkg::OP_STORE: begin
        if (wlen_r < 5'(gww_pkg::STORE_DEPTH)) wlen_nxt = wlen_r + 5'd1;
      end
      gww_pkg::OP_DIRECT: stream_nxt = 1'b1;
      gww_pkg::OP_SPACE:  stream_nxt = 1'b0;
      gww_pkg::OP_RS_WRAP: begin
        len_nxt    = wlen_r;
        wlen_nxt   = 5'd0;
        idx_nxt    = 5'd0;
        stream_nxt = !ended;
        line_nxt   = line_inc;
        col_nxt    = 5'd0;
        if (line_inc >= cfg.elim) full_nxt = 1'b1;
      end
      gww_pkg::OP_RS_SPACE: begin
        len_nxt    = wlen_r;
        wlen_nxt   = 5'd0;
        idx_nxt    = 5'd0;
        stream_nxt = 1'b0;
        col_nxt    = col_r + 5'd1;
      end
      gww_pkg::OP_NEWLINE: begin
        line_nxt = line_inc;
        col_nxt  = 5'd0;
        if (line_inc >= cfg.elim) full_nxt = 1'b1;
      end
      gww_pkg::OP_PUTCHAR: begin
        col_nxt = col_r + 5'd1;
        if (cmd.src_mem) idx_nxt = idx_r + 5'd1;
      end
      gww_pkg::OP_ZFIN: begin
        wlen_nxt   = 5'd0;
        col_nxt    = 5'd0;
        line_nxt   = 4'd0;
        full_nxt   = 1'b0;
        stream_nxt = 1'b0;
      end
      default: char_nxt = char_r;
    endcase

    if (mv_out) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      out_last_nxt  = (cmd.op == gww_pkg::OP_FLUSH);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (push) begin
      pend_valid_nxt = 1'b1;
      pend_nxt       = new_res;
    end else if (cmd.op == gww_pkg::OP_FLUSH) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gww_pkg::OP_STORE && wlen_r < 5'(gww_pkg::STORE_DEPTH)) begin
      store_mem[wlen_r] <= char_r;
    end
    if (cmd.op == gww_pkg::OP_READ) begin
      rdata_r <= store_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r       <= 5'd0;
      col_r        <= 5'd0;
      line_r       <= 4'd0;
      full_r       <= 1'b0;
      stream_r     <= 1'b0;
      nwr_r        <= 6'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      wlen_r       <= wlen_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      full_r       <= full_nxt;
      stream_r     <= stream_nxt;
      nwr_r        <= nwr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    sts.is_zero    = (char_r == gww_pkg::NUL_CODE);
    sts.is_space   = (char_r == gww_pkg::SPACE_CODE);
    sts.full       = full_r;
    sts.stream     = stream_r;
    sts.col_zero   = (col_r == 5'd0);
    sts.wlen_zero  = (wlen_r == 5'd0);
    sts.wrap_chk   = ({1'b0, col_r} + 6'd1 + {1'b0, wlen_r}) > {1'b0, cfg.ew};
    sts.col_at_w   = (col_r >= cfg.ew);
    sts.loop_last  = (idx_r == (len_r - 5'd1));
    sts.wr_ok      = suppress || !pend_valid_r || out_free;
    sts.push_ok    = !pend_valid_r || out_free;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_line_index    = out_r.line_index;
  assign out_column        = out_r.column;
  assign out_char_code_out = out_r.ch;
  assign out_line_total    = out_r.total;
  assign out_last          = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    mv_out |-> out_free)
    else $error("result register overwritten while stalled");

  a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == gww_pkg::OP_ACCEPT) |-> !pend_valid_r)
    else $error("word accepted with a result still pending");

  a_text_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == gww_pkg::OP_ZFIN) |=>
      (line_r == 4'd0 && col_r == 5'd0 && wlen_r == 5'd0 && !full_r))
    else $error("text state not cleared after end of text");

  a_write_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nwr_r <= 6'(gww_pkg::MAX_WRITES))
    else $error("write count above limit");

endmodule

// File: hw/rtl/greedy_word_wrap.sv
// Greedy word wrap: places a byte stream into fixed-width lines and reports each write.
// The input channel (in_valid, in_stall, in_char_code) takes one text byte per word.
// A space ends a word and runs of spaces collapse; byte 0 ends the text.
// The result channel (out_valid, out_stall, out_*) carries one word per line store
// write: a character, a line terminator, or the end-of-text word with the line count.
// out_last marks the final result caused by one input byte.
// A new byte is accepted only in the idle state, once the work of the previous byte is done.
// Flushing a buffered word reads each character from the word buffer memory before it is
// placed, and each hard split adds a line terminator.
// End of text adds a step for the terminator and one for the count.
// A result moves to the output register when the next result of the same byte is formed, or at
// the end of that byte's work; the output register lets a new byte in while it waits.
// When the receiver stalls, the sequencer waits once its pending result cannot move.
// Synchronous reset clears the line position and the word buffer length, empties the
// result path and loads line_width 26 and line_limit 8; the buffer needs no clearing.
// line_width sits at byte address 0 and line_limit at 4 on the APB-style port.
module greedy_word_wrap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_line_index,
  output logic [4:0]  out_column,
  output logic [7:0]  out_char_code_out,
  output logic [3:0]  out_line_total,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gww_pkg::cfg_t cfg;
  gww_pkg::cmd_t cmd;
  gww_pkg::sts_t sts;

  gww_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gww_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gww_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg),
    .in_char_code      (in_char_code),
    .out_stall         (out_stall),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_line_index    (out_line_index),
    .out_column        (out_column),
    .out_char_code_out (out_char_code_out),
    .out_line_total    (out_line_total),
    .out_last          (out_last)
  );

endmodule
